// ----- rtl/phase_current_clarke_scaler_defines.svh -----
// assertion helpers for the scaler rtl
`ifndef PHASE_CURRENT_CLARKE_SCALER_DEFINES_SVH
`define PHASE_CURRENT_CLARKE_SCALER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define CCS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ccs check failed");

// next-cycle implication, disabled while in reset
`define CCS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ccs check failed");

`endif

// ----- rtl/ccs_pkg.sv -----
`default_nettype none

package ccs_pkg;

  // default converter resolution
  localparam int ADC_BITS_DEF = 12;

  // field and datapath widths
  localparam int F_W       = 24;
  localparam int VGAIN_W   = 20;
  localparam int MUL_A_W   = 26;
  localparam int MUL_B_W   = 24;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int SQ_W      = 48;
  localparam int ROOT_W    = 24;
  localparam int REM_W     = ROOT_W + 2;
  localparam int ISQ_CNT_W = $clog2(ROOT_W);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // q16 constants: 1/sqrt3 and 1/sqrt2
  localparam int INV_SQRT3_Q16 = 37837;
  localparam int INV_SQRT2_Q16 = 46341;

  // register reset values
  localparam logic signed [F_W-1:0] CURRENT_GAIN_RST = -24'sd1334;
  localparam logic [VGAIN_W-1:0]    VOLTAGE_GAIN_RST = 20'd15524;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CURRENT_GAIN = 2'd0,
    REG_OFFSET_U     = 2'd1,
    REG_OFFSET_V     = 2'd2,
    REG_VOLTAGE_GAIN = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_U,
    S_MUL_V,
    S_MUL_DC,
    S_PHASE_C,
    S_MUL_BETA,
    S_MUL_A2,
    S_MUL_B2,
    S_SUM,
    S_SQRT,
    S_MUL_RMS,
    S_RMS,
    S_DONE
  } state_t;

  // square root unit status
  typedef struct packed {
    logic busy;
    logic done;
  } isq_stat_t;

  // floor((v + 2^(s-1)) / 2^s)
  function automatic logic signed [PROD_W-1:0] rnd_shift(
    input logic signed [PROD_W-1:0] v,
    input int unsigned s
  );
    logic signed [PROD_W-1:0] t;
    t = v + (PROD_W'(1) << (s - 1));
    return t >>> s;
  endfunction

  // clamp to the signed 24-bit range
  function automatic logic signed [F_W-1:0] sat_s24(input logic signed [PROD_W-1:0] v);
    logic hi_pos;
    logic hi_neg;
    hi_pos = !v[PROD_W-1] && (|v[PROD_W-2:F_W-1]);
    hi_neg = v[PROD_W-1] && !(&v[PROD_W-2:F_W-1]);
    if (hi_pos) begin
      return {1'b0, {(F_W-1){1'b1}}};
    end else if (hi_neg) begin
      return {1'b1, {(F_W-1){1'b0}}};
    end else begin
      return v[F_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ccs_mul.sv -----
`default_nettype none

// shared signed multiplier with a registered product
module ccs_mul (
  input  wire logic                                  clk,
  input  wire logic signed [ccs_pkg::MUL_A_W-1:0]    op_a,
  input  wire logic signed [ccs_pkg::MUL_B_W-1:0]    op_b,
  output logic signed      [ccs_pkg::PROD_W-1:0]     prod_r
);

  logic signed [ccs_pkg::PROD_W-1:0] prod_nxt;

  // full-width signed product
  assign prod_nxt = ccs_pkg::PROD_W'(op_a) * ccs_pkg::PROD_W'(op_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/ccs_isqrt.sv -----
`default_nettype none

// integer square root, one result bit per cycle
module ccs_isqrt (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [ccs_pkg::SQ_W-1:0]       radicand,
  output ccs_pkg::isq_stat_t                  stat,
  output logic      [ccs_pkg::ROOT_W-1:0]     root_r
);

  localparam logic [ccs_pkg::ISQ_CNT_W-1:0] LAST = ccs_pkg::ISQ_CNT_W'(ccs_pkg::ROOT_W - 1);

  logic [ccs_pkg::ISQ_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic [ccs_pkg::SQ_W-1:0]      rad_r;
  logic [ccs_pkg::REM_W-1:0]     rem_r;
  logic [ccs_pkg::REM_W-1:0]     rem_nxt;
  logic [ccs_pkg::ROOT_W-1:0]    root_nxt;
  logic [ccs_pkg::REM_W+1:0]     rem_sh;
  logic [ccs_pkg::REM_W+1:0]     trial;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {rem_r, rad_r[ccs_pkg::SQ_W-1 -: 2]};
    trial  = {2'b00, root_r, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = ccs_pkg::REM_W'(rem_sh - trial);
      root_nxt = {root_r[ccs_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh[ccs_pkg::REM_W-1:0];
      root_nxt = {root_r[ccs_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  // step counter and status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

// ----- rtl/phase_current_clarke_scaler.sv -----
// Phase current Clarke scaler.
// Input channel (in_valid / in_ready): one beat carries the phase U, phase V
// and DC link ADC codes of one PWM period. Result channel (out_valid /
// out_ready): one beat per input beat with the scaled phase currents, the
// alpha / beta components, vector magnitude and rms, DC link volts and the
// DC link peak. Configuration (cfg_we / cfg_index / cfg_wdata) writes gains
// and offsets; write only while no beat is in flight.
// The block takes no new input beat until the sequencer has finished the
// last one. The sequencer runs one shared multiplier seven times in sequence
// plus a 24-step square root unit that produces one root bit per cycle.
// in_ready is high only while the sequencer is idle. The finished beat sits
// in an output register, so the next input beat is taken while the receiver
// stalls; a second finished beat waits in the sequencer until the first is
// taken.
// Reset: synchronous, active low. It clears the sequencer, drops out_valid,
// restores default gains and offsets and clears the DC link peak.
`default_nettype none

`include "phase_current_clarke_scaler_defines.svh"

module phase_current_clarke_scaler #(
  parameter int ADC_BITS = ccs_pkg::ADC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // configuration
  input  wire logic                                 cfg_we,
  input  wire logic [ccs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [ccs_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  // input beat
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [ADC_BITS-1:0]                  in_code_u,
  input  wire logic [ADC_BITS-1:0]                  in_code_v,
  input  wire logic [ADC_BITS-1:0]                  in_code_dc,
  // result beat
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [ccs_pkg::F_W-1:0]            out_current_a,
  output logic signed [ccs_pkg::F_W-1:0]            out_current_b,
  output logic signed [ccs_pkg::F_W-1:0]            out_current_c,
  output logic signed [ccs_pkg::F_W-1:0]            out_alpha,
  output logic signed [ccs_pkg::F_W-1:0]            out_beta,
  output logic        [ccs_pkg::F_W-1:0]            out_magnitude,
  output logic        [ccs_pkg::F_W-1:0]            out_magnitude_rms,
  output logic        [ccs_pkg::F_W-1:0]            out_dc_volts,
  output logic        [ccs_pkg::F_W-1:0]            out_dc_peak
);

  localparam int FW = ccs_pkg::F_W;
  localparam int PW = ccs_pkg::PROD_W;
  localparam logic signed [ADC_BITS:0] MID_S = (ADC_BITS + 1)'((1 << (ADC_BITS - 1)) - 1);

  // configuration registers
  logic signed [FW-1:0]               gain_r;
  logic signed [FW-1:0]               off_u_r;
  logic signed [FW-1:0]               off_v_r;
  logic [ccs_pkg::VGAIN_W-1:0]        vgain_r;

  // sequencer
  ccs_pkg::state_t                    state_r;
  ccs_pkg::state_t                    state_nxt;
  logic                               out_valid_r;
  logic                               out_valid_nxt;
  logic                               load_out;
  logic                               sq_start;

  // working registers
  logic [ADC_BITS-1:0]                code_u_r;
  logic [ADC_BITS-1:0]                code_v_r;
  logic [ADC_BITS-1:0]                code_dc_r;
  logic signed [FW-1:0]               a_r;
  logic signed [FW-1:0]               b_r;
  logic signed [FW-1:0]               c_r;
  logic signed [FW-1:0]               beta_r;
  logic [FW-1:0]                      volts_r;
  logic [FW-1:0]                      peak_r;
  logic [ccs_pkg::SQ_W-1:0]           sq_r;
  logic [FW-1:0]                      mag_r;
  logic [FW-1:0]                      rms_r;

  // output registers
  logic signed [FW-1:0]               o_a_r;
  logic signed [FW-1:0]               o_b_r;
  logic signed [FW-1:0]               o_c_r;
  logic signed [FW-1:0]               o_beta_r;
  logic [FW-1:0]                      o_mag_r;
  logic [FW-1:0]                      o_rms_r;
  logic [FW-1:0]                      o_volts_r;
  logic [FW-1:0]                      o_peak_r;

  // shared multiplier and root unit
  logic signed [ccs_pkg::MUL_A_W-1:0] mul_a;
  logic signed [ccs_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0]               prod_r;
  ccs_pkg::isq_stat_t                 isq_stat;
  logic [ccs_pkg::ROOT_W-1:0]         root;

  // datapath helpers
  logic signed [ADC_BITS:0]           diff_u;
  logic signed [ADC_BITS:0]           diff_v;
  logic signed [FW:0]                 b_minus_c;
  logic signed [FW+1:0]               neg_ab;
  logic signed [PW-1:0]               rnd8;
  logic signed [PW-1:0]               rnd16;
  logic signed [PW-1:0]               phase_u;
  logic signed [PW-1:0]               phase_v;
  logic [FW-1:0]                      volts_sat;
  logic [ccs_pkg::SQ_W-1:0]           radicand;

  assign diff_u    = $signed({1'b0, code_u_r}) - MID_S;
  assign diff_v    = $signed({1'b0, code_v_r}) - MID_S;
  assign b_minus_c = (FW + 1)'(b_r) - (FW + 1)'(c_r);
  assign neg_ab    = -((FW + 2)'(a_r) + (FW + 2)'(b_r));
  assign rnd8      = ccs_pkg::rnd_shift(prod_r, 8);
  assign rnd16     = ccs_pkg::rnd_shift(prod_r, 16);
  assign phase_u   = rnd8 - PW'(off_u_r);
  assign phase_v   = rnd8 - PW'(off_v_r);
  assign volts_sat = (|rnd8[PW-1:FW]) ? '1 : rnd8[FW-1:0];
  assign radicand  = sq_r + prod_r[ccs_pkg::SQ_W-1:0];

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= ccs_pkg::CURRENT_GAIN_RST;
      off_u_r <= '0;
      off_v_r <= '0;
      vgain_r <= ccs_pkg::VOLTAGE_GAIN_RST;
    end else if (cfg_we) begin
      case (ccs_pkg::cfg_reg_t'(cfg_index))
        ccs_pkg::REG_CURRENT_GAIN: gain_r  <= cfg_wdata[FW-1:0];
        ccs_pkg::REG_OFFSET_U:     off_u_r <= cfg_wdata[FW-1:0];
        ccs_pkg::REG_OFFSET_V:     off_v_r <= cfg_wdata[FW-1:0];
        ccs_pkg::REG_VOLTAGE_GAIN: vgain_r <= cfg_wdata[ccs_pkg::VGAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ccs_pkg::S_MUL_U: begin
        mul_a = ccs_pkg::MUL_A_W'(diff_u);
        mul_b = gain_r;
      end
      ccs_pkg::S_MUL_V: begin
        mul_a = ccs_pkg::MUL_A_W'(diff_v);
        mul_b = gain_r;
      end
      ccs_pkg::S_MUL_DC: begin
        mul_a = ccs_pkg::MUL_A_W'(code_dc_r);
        mul_b = ccs_pkg::MUL_B_W'(vgain_r);
      end
      ccs_pkg::S_MUL_BETA: begin
        mul_a = ccs_pkg::MUL_A_W'(b_minus_c);
        mul_b = ccs_pkg::MUL_B_W'(ccs_pkg::INV_SQRT3_Q16);
      end
      ccs_pkg::S_MUL_A2: begin
        mul_a = ccs_pkg::MUL_A_W'(a_r);
        mul_b = a_r;
      end
      ccs_pkg::S_MUL_B2: begin
        mul_a = ccs_pkg::MUL_A_W'(beta_r);
        mul_b = beta_r;
      end
      ccs_pkg::S_MUL_RMS: begin
        mul_a = ccs_pkg::MUL_A_W'(mag_r);
        mul_b = ccs_pkg::MUL_B_W'(ccs_pkg::INV_SQRT2_Q16);
      end
      default: ;
    endcase
  end

  ccs_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  ccs_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (radicand),
    .stat     (isq_stat),
    .root_r   (root)
  );

  // sequencer next state and outputs
  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    sq_start      = 1'b0;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ccs_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ccs_pkg::S_MUL_U;
        end
      end
      ccs_pkg::S_MUL_U:    state_nxt = ccs_pkg::S_MUL_V;
      ccs_pkg::S_MUL_V:    state_nxt = ccs_pkg::S_MUL_DC;
      ccs_pkg::S_MUL_DC:   state_nxt = ccs_pkg::S_PHASE_C;
      ccs_pkg::S_PHASE_C:  state_nxt = ccs_pkg::S_MUL_BETA;
      ccs_pkg::S_MUL_BETA: state_nxt = ccs_pkg::S_MUL_A2;
      ccs_pkg::S_MUL_A2:   state_nxt = ccs_pkg::S_MUL_B2;
      ccs_pkg::S_MUL_B2:   state_nxt = ccs_pkg::S_SUM;
      ccs_pkg::S_SUM: begin
        sq_start  = 1'b1;
        state_nxt = ccs_pkg::S_SQRT;
      end
      ccs_pkg::S_SQRT: begin
        if (isq_stat.done) begin
          state_nxt = ccs_pkg::S_MUL_RMS;
        end
      end
      ccs_pkg::S_MUL_RMS:  state_nxt = ccs_pkg::S_RMS;
      ccs_pkg::S_RMS:      state_nxt = ccs_pkg::S_DONE;
      ccs_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ccs_pkg::S_IDLE;
        end
      end
      default: state_nxt = ccs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ccs_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // running dc link peak
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
    end else if (state_r == ccs_pkg::S_MUL_BETA && volts_r > peak_r) begin
      peak_r <= volts_r;
    end
  end

  // working registers, each written in its own step
  always_ff @(posedge clk) begin
    case (state_r)
      ccs_pkg::S_IDLE: begin
        if (in_valid) begin
          code_u_r  <= in_code_u;
          code_v_r  <= in_code_v;
          code_dc_r <= in_code_dc;
        end
      end
      ccs_pkg::S_MUL_V:   a_r     <= ccs_pkg::sat_s24(phase_u);
      ccs_pkg::S_MUL_DC:  b_r     <= ccs_pkg::sat_s24(phase_v);
      ccs_pkg::S_PHASE_C: begin
        c_r     <= ccs_pkg::sat_s24(PW'(neg_ab));
        volts_r <= volts_sat;
      end
      ccs_pkg::S_MUL_A2:  beta_r  <= ccs_pkg::sat_s24(rnd16);
      ccs_pkg::S_MUL_B2:  sq_r    <= prod_r[ccs_pkg::SQ_W-1:0];
      ccs_pkg::S_SQRT: begin
        if (isq_stat.done) begin
          mag_r <= root;
        end
      end
      ccs_pkg::S_RMS:     rms_r   <= rnd16[FW-1:0];
      default: ;
    endcase
  end

  // output register, frees the sequencer for the next beat
  always_ff @(posedge clk) begin
    if (load_out) begin
      o_a_r     <= a_r;
      o_b_r     <= b_r;
      o_c_r     <= c_r;
      o_beta_r  <= beta_r;
      o_mag_r   <= mag_r;
      o_rms_r   <= rms_r;
      o_volts_r <= volts_r;
      o_peak_r  <= peak_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_current_a     = o_a_r;
  assign out_current_b     = o_b_r;
  assign out_current_c     = o_c_r;
  assign out_alpha         = o_a_r;
  assign out_beta          = o_beta_r;
  assign out_magnitude     = o_mag_r;
  assign out_magnitude_rms = o_rms_r;
  assign out_dc_volts      = o_volts_r;
  assign out_dc_peak       = o_peak_r;

  // checks
  `CCS_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `CCS_ASSERT_NXT(a_peak_monotonic, clk, rst_n, 1'b1, peak_r >= $past(peak_r))
  `CCS_ASSERT_IMP(a_peak_covers_volts, clk, rst_n, out_valid, out_dc_peak >= out_dc_volts)
  `CCS_ASSERT_IMP(a_rms_below_mag, clk, rst_n, out_valid, out_magnitude_rms <= out_magnitude)
  `CCS_ASSERT_IMP(a_root_in_sqrt, clk, rst_n, isq_stat.done, state_r == ccs_pkg::S_SQRT)

endmodule

`default_nettype wire

// ----- tb/phase_current_clarke_scaler_tb.sv -----
`timescale 1ns / 100ps

module phase_current_clarke_scaler_tb;

  localparam int ADC_W      = ccs_pkg::ADC_BITS_DEF;
  localparam int CYCLE_CAP  = 1000000;
  localparam int MAX_SHOWN  = 10;
  localparam int RAND_ITEMS = 82;
  localparam int RAND_PHASES = 8;

  typedef struct packed {
    logic [ccs_pkg::F_W-1:0] current_a;
    logic [ccs_pkg::F_W-1:0] current_b;
    logic [ccs_pkg::F_W-1:0] current_c;
    logic [ccs_pkg::F_W-1:0] alpha;
    logic [ccs_pkg::F_W-1:0] beta;
    logic [ccs_pkg::F_W-1:0] magnitude;
    logic [ccs_pkg::F_W-1:0] magnitude_rms;
    logic [ccs_pkg::F_W-1:0] dc_volts;
    logic [ccs_pkg::F_W-1:0] dc_peak;
  } clarke_result_t;

  // scoreboard: fixed point model of the scaler plus the queue of predicted beats
  class clarke_scoreboard;
    longint current_gain;
    longint offset_u;
    longint offset_v;
    longint voltage_gain;
    longint peak_volts;
    clarke_result_t predicted_results[$];
    int errors;
    int beats_checked;

    function void reset_state();
      current_gain = -1334;
      offset_u     = 0;
      offset_v     = 0;
      voltage_gain = 15524;
      peak_volts   = 0;
      predicted_results.delete();
      errors       = 0;
      beats_checked = 0;
    endfunction

    function void write_reg(ccs_pkg::cfg_reg_t idx, logic [ccs_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        ccs_pkg::REG_CURRENT_GAIN:
          current_gain = longint'($signed(data[ccs_pkg::F_W-1:0]));
        ccs_pkg::REG_OFFSET_U:     offset_u = longint'($signed(data[ccs_pkg::F_W-1:0]));
        ccs_pkg::REG_OFFSET_V:     offset_v = longint'($signed(data[ccs_pkg::F_W-1:0]));
        ccs_pkg::REG_VOLTAGE_GAIN:
          voltage_gain = longint'(data[ccs_pkg::VGAIN_W-1:0]);
        default: ;
      endcase
    endfunction

    // round half up, then floor
    function longint round_half_up(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint clamp_s24(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > n) probe = probe >> 2;
      while (probe != 0) begin
        if (n >= root + probe) begin
          n    = n - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root = root >> 1;
        end
        probe = probe >> 2;
      end
      return root;
    endfunction

    function longint phase_amps(logic [ADC_W-1:0] code, longint offset);
      longint mid;
      mid = (longint'(1) << (ADC_W - 1)) - 1;
      return clamp_s24(round_half_up(current_gain * (longint'(code) - mid), 8) - offset);
    endfunction

    // accepted input beat: predict its result
    function void note_beat(logic [ADC_W-1:0] code_u, logic [ADC_W-1:0] code_v,
                            logic [ADC_W-1:0] code_dc);
      longint a, b, c, beta, mag, rms, volts;
      longint unsigned sq;
      clarke_result_t r;
      a     = phase_amps(code_u, offset_u);
      b     = phase_amps(code_v, offset_v);
      c     = clamp_s24(-(a + b));
      beta  = clamp_s24(round_half_up((b - c) * ccs_pkg::INV_SQRT3_Q16, 16));
      sq    = longint'(a * a) + longint'(beta * beta);
      mag   = longint'(int_sqrt(sq));
      rms   = round_half_up(mag * ccs_pkg::INV_SQRT2_Q16, 16);
      volts = round_half_up(voltage_gain * longint'(code_dc), 8);
      if (volts > 64'sd16777215) volts = 64'sd16777215;
      if (volts > peak_volts) peak_volts = volts;
      r.current_a     = a[ccs_pkg::F_W-1:0];
      r.current_b     = b[ccs_pkg::F_W-1:0];
      r.current_c     = c[ccs_pkg::F_W-1:0];
      r.alpha         = a[ccs_pkg::F_W-1:0];
      r.beta          = beta[ccs_pkg::F_W-1:0];
      r.magnitude     = mag[ccs_pkg::F_W-1:0];
      r.magnitude_rms = rms[ccs_pkg::F_W-1:0];
      r.dc_volts      = volts[ccs_pkg::F_W-1:0];
      r.dc_peak       = peak_volts[ccs_pkg::F_W-1:0];
      predicted_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [ccs_pkg::F_W-1:0] exp_v,
                                logic [ccs_pkg::F_W-1:0] act_v);
      if (exp_v !== act_v) begin
        if (errors < MAX_SHOWN)
          $display("beat %0d %s mismatch: expected %h got %h",
                   beats_checked, name, exp_v, act_v);
        errors++;
      end
    endfunction

    // accepted result beat: compare with the oldest prediction
    function void check_beat(clarke_result_t got);
      clarke_result_t want;
      if (predicted_results.size() == 0) begin
        if (errors < MAX_SHOWN)
          $display("unexpected result beat %0d: %h", beats_checked, got);
        errors++;
      end else begin
        want = predicted_results.pop_front();
        compare_field("current_a", want.current_a, got.current_a);
        compare_field("current_b", want.current_b, got.current_b);
        compare_field("current_c", want.current_c, got.current_c);
        compare_field("alpha", want.alpha, got.alpha);
        compare_field("beta", want.beta, got.beta);
        compare_field("magnitude", want.magnitude, got.magnitude);
        compare_field("magnitude_rms", want.magnitude_rms, got.magnitude_rms);
        compare_field("dc_volts", want.dc_volts, got.dc_volts);
        compare_field("dc_peak", want.dc_peak, got.dc_peak);
      end
      beats_checked++;
    endfunction

    function int pending();
      return predicted_results.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [ccs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ccs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [ADC_W-1:0]               in_code_u = '0;
  logic [ADC_W-1:0]               in_code_v = '0;
  logic [ADC_W-1:0]               in_code_dc = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic signed [ccs_pkg::F_W-1:0] out_current_a;
  logic signed [ccs_pkg::F_W-1:0] out_current_b;
  logic signed [ccs_pkg::F_W-1:0] out_current_c;
  logic signed [ccs_pkg::F_W-1:0] out_alpha;
  logic signed [ccs_pkg::F_W-1:0] out_beta;
  logic [ccs_pkg::F_W-1:0]        out_magnitude;
  logic [ccs_pkg::F_W-1:0]        out_magnitude_rms;
  logic [ccs_pkg::F_W-1:0]        out_dc_volts;
  logic [ccs_pkg::F_W-1:0]        out_dc_peak;

  clarke_scoreboard sb;
  int  cycle_count = 0;
  bit  src_stalls = 1'b0;
  bit  sink_stalls = 1'b0;

  phase_current_clarke_scaler #(
    .ADC_BITS(ADC_W)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_code_u        (in_code_u),
    .in_code_v        (in_code_v),
    .in_code_dc       (in_code_dc),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_current_a    (out_current_a),
    .out_current_b    (out_current_b),
    .out_current_c    (out_current_c),
    .out_alpha        (out_alpha),
    .out_beta         (out_beta),
    .out_magnitude    (out_magnitude),
    .out_magnitude_rms(out_magnitude_rms),
    .out_dc_volts     (out_dc_volts),
    .out_dc_peak      (out_dc_peak)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // beat monitors on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_beat(in_code_u, in_code_v, in_code_dc);
      if (out_valid && out_ready)
        sb.check_beat('{out_current_a, out_current_b, out_current_c, out_alpha, out_beta,
                        out_magnitude, out_magnitude_rms, out_dc_volts, out_dc_peak});
    end
  end

  // gap length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  // result side back-pressure
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (!sink_stalls || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
      end else begin
        gap = pick_gap();
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [ADC_W-1:0] pick_code();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return ADC_W'($urandom_range(2040, 2055));
    return ADC_W'($urandom_range(0, (1 << ADC_W) - 1));
  endfunction

  function automatic logic [ccs_pkg::CFG_DATA_W-1:0] pick_gain();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 24'h7fffff;
    if (r == 1) return 24'h800000;
    if (r == 2) return '0;
    if (r < 7) return 24'(int'($urandom_range(0, 6000)) - 3000);
    return 24'($urandom());
  endfunction

  function automatic logic [ccs_pkg::CFG_DATA_W-1:0] pick_offset();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return 24'h7fffff;
    if (r == 2) return 24'h800000;
    if (r < 6) return 24'(int'($urandom_range(0, 8000)) - 4000);
    return 24'($urandom());
  endfunction

  // upper four bits lie beyond the register and are random
  function automatic logic [ccs_pkg::CFG_DATA_W-1:0] pick_vgain();
    int r;
    logic [ccs_pkg::VGAIN_W-1:0] g;
    r = $urandom_range(0, 7);
    if (r == 0) g = '0;
    else if (r == 1) g = '1;
    else if (r < 5) g = ccs_pkg::VGAIN_W'($urandom_range(10000, 20000));
    else g = ccs_pkg::VGAIN_W'($urandom());
    return {4'($urandom()), g};
  endfunction

  task automatic write_reg(ccs_pkg::cfg_reg_t idx, logic [ccs_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // sender holds off until every predicted beat has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // new phase: wait for idle, then load all four registers
  task automatic begin_phase(logic [ccs_pkg::CFG_DATA_W-1:0] gain,
                             logic [ccs_pkg::CFG_DATA_W-1:0] off_u,
                             logic [ccs_pkg::CFG_DATA_W-1:0] off_v,
                             logic [ccs_pkg::CFG_DATA_W-1:0] vgain,
                             bit src, bit sink);
    drain();
    src_stalls  = src;
    sink_stalls = sink;
    write_reg(ccs_pkg::REG_CURRENT_GAIN, gain);
    write_reg(ccs_pkg::REG_OFFSET_U, off_u);
    write_reg(ccs_pkg::REG_OFFSET_V, off_v);
    write_reg(ccs_pkg::REG_VOLTAGE_GAIN, vgain);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // one input beat, then a random hold-off
  task automatic send_codes(logic [ADC_W-1:0] u, logic [ADC_W-1:0] v,
                            logic [ADC_W-1:0] dc);
    int gap;
    in_valid   <= 1'b1;
    in_code_u  <= u;
    in_code_v  <= v;
    in_code_dc <= dc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = 0;
    if (src_stalls && $urandom_range(0, 2) != 0) gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: zero current, code extremes, peak holding over lower dc
    send_codes(12'd2047, 12'd2047, 12'd0);
    send_codes(12'd0, 12'd0, 12'd4095);
    send_codes(12'd4095, 12'd4095, 12'd4095);
    send_codes(12'd0, 12'd4095, 12'd1);
    send_codes(12'd4095, 12'd0, 12'd2048);
    send_codes(12'd2048, 12'd2046, 12'd100);

    // largest gain: phase, phase W and beta saturation; ignored upper gain bits
    begin_phase(24'h7fffff, 24'h000000, 24'h000000, 24'hffffff, 1'b1, 1'b1);
    send_codes(12'd4095, 12'd4095, 12'd4095);
    send_codes(12'd0, 12'd0, 12'd4095);
    send_codes(12'd4095, 12'd0, 12'd0);
    send_codes(12'd2048, 12'd2047, 12'd10);
    send_codes(12'd0, 12'd4095, 12'd4095);

    // most negative gain, offset extremes, zero voltage gain
    begin_phase(24'h800000, 24'h7fffff, 24'h800000, 24'hf00000, 1'b1, 1'b1);
    send_codes(12'd4095, 12'd4095, 12'd4095);
    send_codes(12'd0, 12'd0, 12'd0);
    send_codes(12'd2047, 12'd2047, 12'd2047);
    send_codes(12'd4095, 12'd0, 12'd1000);

    // zero gain: the phase currents are the negated offsets alone
    begin_phase(24'h000000, 24'h000123, 24'hfff800, 24'h003ca4, 1'b0, 1'b1);
    send_codes(12'd2047, 12'd2047, 12'd123);
    send_codes(12'd1, 12'd4094, 12'd4094);

    // random phases, each with its own register setting
    for (int p = 0; p < RAND_PHASES; p++) begin
      begin_phase(pick_gain(), pick_offset(), pick_offset(), pick_vgain(),
                  p == 2 || p > 2, p == 1 || p > 2);
      for (int k = 0; k < RAND_ITEMS; k++)
        send_codes(pick_code(), pick_code(), pick_code());
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
